>>> rtl/tpmq_pkg.sv
package tpmq_pkg;

    localparam logic [28:0] LOW_PRIO_MASK = 29'h1C00_0000;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        cmd;
        logic [28:0] ident;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic        is_extended;
        logic        is_remote;
    } in_t;

    typedef struct packed {
        logic        out_valid;
        logic [28:0] out_ident;
        logic [3:0]  out_count;
        logic [63:0] out_payload;
        logic        out_extended;
        logic        out_remote;
        logic        dropped;
        logic        went_high;
    } out_t;

    typedef struct packed {
        logic        is_remote;
        logic        is_extended;
        logic [3:0]  byte_count;
        logic [28:0] ident;
        logic [63:0] payload;
    } entry_t;

endpackage

>>> rtl/tpmq_ram.sv
module tpmq_ram #(
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  tpmq_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output tpmq_pkg::entry_t     rd_data
);

    tpmq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/two_priority_message_queue_top.sv
// Enqueue: result registered, valid on the cycle after the item is accepted.
// Dequeue: the memory read data is registered, then the result is registered in ST_READ.
// Throughput: one enqueue per cycle while the output is not stalled; no item is accepted
// in ST_READ, while a dequeue waits on the registered read port of the queue memories.
// Reset (aresetn low, synchronous): pointers, fill counts and handshake cleared;
// queue memory contents are not cleared.
module two_priority_message_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tpmq_pkg::in_t  s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output tpmq_pkg::out_t m_item
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] n);
        logic [63:0] r;
        r = d;
        for (int i = 0; i < 8; i++) begin
            if (n <= 4'(i)) begin
                r[i*8 +: 8] = 8'h00;
            end
        end
        keep_bytes = r;
    endfunction

    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    tpmq_pkg::out_t      m_item_reg, m_item_next;
    logic                sel_high_reg, sel_high_next;
    logic [PTR_W-1:0]    high_rd_reg, high_rd_next, high_wr_reg, high_wr_next;
    logic [PTR_W-1:0]    normal_rd_reg, normal_rd_next, normal_wr_reg, normal_wr_next;
    logic [FILL_W-1:0]   high_fill_reg, high_fill_next, normal_fill_reg, normal_fill_next;

    logic                s_accept;
    logic                is_normal;
    logic                high_full, normal_full;
    logic                high_wr_en, normal_wr_en, high_rd_en, normal_rd_en;
    tpmq_pkg::entry_t    wr_entry, high_rdata, normal_rdata, rd_entry;

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    assign is_normal   = (s_item.ident & tpmq_pkg::LOW_PRIO_MASK) != '0;
    assign high_full   = high_fill_reg == FILL_MAX;
    assign normal_full = normal_fill_reg == FILL_MAX;

    assign high_wr_en   = s_accept && (s_item.cmd == tpmq_pkg::CMD_ENQUEUE)
                          && !is_normal && !high_full;
    assign normal_wr_en = s_accept && (s_item.cmd == tpmq_pkg::CMD_ENQUEUE)
                          && is_normal && !normal_full;
    assign high_rd_en   = s_accept && (s_item.cmd == tpmq_pkg::CMD_DEQUEUE)
                          && (high_fill_reg != '0);
    assign normal_rd_en = s_accept && (s_item.cmd == tpmq_pkg::CMD_DEQUEUE)
                          && (high_fill_reg == '0) && (normal_fill_reg != '0);

    always_comb begin
        wr_entry.is_remote   = s_item.is_remote;
        wr_entry.is_extended = s_item.is_extended;
        wr_entry.byte_count  = s_item.byte_count;
        wr_entry.ident       = s_item.ident;
        wr_entry.payload     = keep_bytes(s_item.payload, s_item.byte_count);
    end

    tpmq_ram #(.DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_high_ram (
        .aclk    (aclk),
        .wr_en   (high_wr_en),
        .wr_addr (high_wr_reg),
        .wr_data (wr_entry),
        .rd_en   (high_rd_en),
        .rd_addr (high_rd_reg),
        .rd_data (high_rdata)
    );

    tpmq_ram #(.DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_normal_ram (
        .aclk    (aclk),
        .wr_en   (normal_wr_en),
        .wr_addr (normal_wr_reg),
        .wr_data (wr_entry),
        .rd_en   (normal_rd_en),
        .rd_addr (normal_rd_reg),
        .rd_data (normal_rdata)
    );

    assign rd_entry = sel_high_reg ? high_rdata : normal_rdata;

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        m_item_next      = m_item_reg;
        sel_high_next    = sel_high_reg;
        high_rd_next     = high_rd_reg;
        high_wr_next     = high_wr_reg;
        high_fill_next   = high_fill_reg;
        normal_rd_next   = normal_rd_reg;
        normal_wr_next   = normal_wr_reg;
        normal_fill_next = normal_fill_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_item.cmd == tpmq_pkg::CMD_ENQUEUE) begin
                        m_valid_next          = 1'b1;
                        m_item_next           = '0;
                        m_item_next.went_high = !is_normal;
                        m_item_next.dropped   = is_normal ? normal_full : high_full;
                        if (high_wr_en) begin
                            high_wr_next   = next_ptr(high_wr_reg);
                            high_fill_next = high_fill_reg + 1'b1;
                        end
                        if (normal_wr_en) begin
                            normal_wr_next   = next_ptr(normal_wr_reg);
                            normal_fill_next = normal_fill_reg + 1'b1;
                        end
                    end else if (high_rd_en) begin
                        sel_high_next  = 1'b1;
                        high_rd_next   = next_ptr(high_rd_reg);
                        high_fill_next = high_fill_reg - 1'b1;
                        state_next     = ST_READ;
                    end else if (normal_rd_en) begin
                        sel_high_next    = 1'b0;
                        normal_rd_next   = next_ptr(normal_rd_reg);
                        normal_fill_next = normal_fill_reg - 1'b1;
                        state_next       = ST_READ;
                    end else begin
                        // both queues empty
                        m_valid_next = 1'b1;
                        m_item_next  = '0;
                    end
                end
            end
            ST_READ: begin
                m_valid_next             = 1'b1;
                m_item_next.out_valid    = 1'b1;
                m_item_next.out_ident    = rd_entry.ident;
                m_item_next.out_count    = rd_entry.byte_count;
                m_item_next.out_payload  = rd_entry.payload;
                m_item_next.out_extended = rd_entry.is_extended;
                m_item_next.out_remote   = rd_entry.is_remote;
                m_item_next.dropped      = 1'b0;
                m_item_next.went_high    = sel_high_reg;
                state_next               = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            sel_high_reg    <= 1'b0;
            high_rd_reg     <= '0;
            high_wr_reg     <= '0;
            high_fill_reg   <= '0;
            normal_rd_reg   <= '0;
            normal_wr_reg   <= '0;
            normal_fill_reg <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            sel_high_reg    <= sel_high_next;
            high_rd_reg     <= high_rd_next;
            high_wr_reg     <= high_wr_next;
            high_fill_reg   <= high_fill_next;
            normal_rd_reg   <= normal_rd_next;
            normal_wr_reg   <= normal_wr_next;
            normal_fill_reg <= normal_fill_next;
        end
        m_item_reg <= m_item_next;
    end

endmodule

>>> rtl/tpmq_checker.sv
module tpmq_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input tpmq_pkg::out_t m_item
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_msg_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.out_valid |-> !m_item.dropped)
        else $error("dequeued item flagged as dropped");

    a_no_msg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.out_valid |->
            m_item.out_ident == '0 && m_item.out_count == '0 &&
            m_item.out_payload == '0 && !m_item.out_extended && !m_item.out_remote)
        else $error("message fields set without a message");

    a_tail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.out_valid && m_item.out_count < 4'd8 |->
            (m_item.out_payload >> {m_item.out_count, 3'b000}) == 64'd0)
        else $error("payload bytes beyond count not cleared");

endmodule

bind two_priority_message_queue_top tpmq_checker u_tpmq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
